[rtl/core/abm_pkg.sv]
package abm_pkg;

   // Field and register widths
   localparam int SAMPLE_W   = 10;
   localparam int SUM_W      = 12;
   localparam int AVG_W      = 10;
   localparam int MODE_W     = 2;
   localparam int BANDGAP_W  = 11;
   localparam int AVCC_W     = 12;
   localparam int VALUE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Burst shape: first sample dropped, the rest averaged
   localparam int BURST_LEN = 4;
   localparam int POS_W     = 2;
   localparam int KEEP_DIV  = BURST_LEN - 1;

   // Full scale of 1024 counts is a shift by ten
   localparam int FS_SHIFT  = 10;
   localparam int SOLAR_NUM = 49;
   localparam int SOLAR_W   = 6;
   localparam int SOLAR_DEN = 10;

   // Divider and multiplier widths
   localparam int DVD_W  = BANDGAP_W + FS_SHIFT;
   localparam int CNT_W  = 5;
   localparam int PROD_W = AVG_W + AVCC_W;
   localparam int VADC_W = PROD_W - FS_SHIFT;
   localparam int M49_W  = VADC_W + SOLAR_W;

   // Reciprocal multiplies for the constant divides
   localparam int RECIP_W    = 16;
   localparam int AVG_RECIP  = 2731;   // ceil(2^13 / 3), exact below 8192
   localparam int AVG_SHIFT  = 13;
   localparam int AVG_PROD_W = SUM_W + RECIP_W;
   localparam int TEN_RECIP  = 52429;  // ceil(2^19 / 10), exact below 2^18
   localparam int TEN_SHIFT  = 19;
   localparam int TEN_PROD_W = M49_W + RECIP_W;
   localparam int TEN_Q_W    = TEN_PROD_W - TEN_SHIFT;

   // Microprogram
   localparam int STEP_W = 4;

   // Register reset values
   localparam logic [MODE_W-1:0]    MODE_RESET    = '0;
   localparam logic [BANDGAP_W-1:0] BANDGAP_RESET = BANDGAP_W'(1100);
   localparam logic [AVCC_W-1:0]    AVCC_RESET    = AVCC_W'(3300);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDGAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVCC    = 2'd2;

   // Conversion modes; anything else gives the raw average
   localparam logic [MODE_W-1:0] MODE_SUPPLY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SOLAR  = 2'd1;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_AVG,
      OP_LOAD,
      OP_DIV_STEP,
      OP_MUL_AVCC,
      OP_MUL_SOLAR,
      OP_DIV_TEN,
      OP_RES_AVG,
      OP_RES_QUOT
   } op_type;

   typedef enum logic [2:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_DIV_BUSY,
      JMP_MODE_SUPPLY,
      JMP_MODE_SOLAR,
      JMP_AVG_ZERO
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
      logic                last;
      logic                force_sat;
   } ucode_type;

   typedef struct packed {
      logic div_busy;
      logic mode_supply;
      logic mode_solar;
      logic avg_zero;
   } stat_type;

   localparam ucode_type UCODE_NOP = '{op: OP_NOP, cond: JMP_NONE, target: '0,
                                       last: 1'b0, force_sat: 1'b0};

endpackage

[rtl/core/adc_burst_average_to_millivolts_unit.sv]
// ADC burst averager. Samples arrive as req transactions; one with tuser set
// opens a burst and is dropped while the reference settles. The next three
// samples are summed as they are accepted; the third of them closes the
// burst and hands the sum to a small microcoded engine that averages it
// (floor of sum / 3) and converts by csr mode: 0 gives supply millivolts
// (bandgap_mv * 1024 / average), 1 gives solar millivolts
// ((average * avcc_mv / 1024) * 49 / 10), 2 or 3 give the raw average. Values
// above 65535, and a zero average in mode 0, come out as 65535 with tuser set.
// Samples with tuser clear outside a burst are dropped. Samples other than the
// closing one are accepted back to back while the engine is idle. The closing
// sample keeps req_tready low while the program runs. Supply millivolts use a
// restoring divider that yields one quotient bit per cycle over 21 bits; the
// divides by 3 and by 10 are reciprocal multiplies.
// The final step holds, with req_tready still low, while an older result waits
// unaccepted. The result waits in an output register, so the next burst may
// start while it is still pending. Write csr registers only while the block
// is idle.
module adc_burst_average_to_millivolts_unit
   import abm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sample transactions
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [9:0] sample
   input  logic                  req_tuser,   // [0] start_burst
   // result transactions
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_W-1:0]    rsp_tdata,   // [15:0] value
   output logic                  rsp_tuser,   // [0] saturated
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [BANDGAP_W-1:0] bandgap_ff, bandgap_in;
   logic [AVCC_W-1:0]    avcc_ff, avcc_in;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic                 req_fire;
   logic                 launch;
   logic                 seq_busy;
   logic                 emit;
   logic                 out_full;
   ucode_type            ctrl;
   stat_type             stat;
   logic [VALUE_W-1:0]   res_value;
   logic                 res_sat;
   logic [SAMPLE_W-1:0]  sample;
   logic [SUM_W-1:0]     sum_next;

   assign sample     = req_tdata[SAMPLE_W-1:0];
   assign req_tready = !seq_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign sum_next   = sum_ff + SUM_W'(sample);

   // Hold the engine on its final step while an older result is still waiting
   assign out_full = rsp_valid_ff && !rsp_tready;

   // Burst tracking, updated on each accepted sample
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      launch = 1'b0;
      if (req_fire) begin
         if (req_tuser) begin
            // restart the burst, drop this sample
            pos_in = POS_W'(1);
            sum_in = '0;
         end else if (pos_ff != '0) begin
            sum_in = sum_next;
            if (pos_ff == POS_W'(BURST_LEN - 1)) begin
               // closing sample: the sum stays put for the engine
               pos_in = '0;
               launch = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   // Configuration registers
   always_comb begin
      mode_in    = mode_ff;
      bandgap_in = bandgap_ff;
      avcc_in    = avcc_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:    mode_in    = csr_wdata[MODE_W-1:0];
            CSR_BANDGAP: bandgap_in = csr_wdata[BANDGAP_W-1:0];
            CSR_AVCC:    avcc_in    = csr_wdata[AVCC_W-1:0];
            default: ;
         endcase
      end
   end

   // Output register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value;
         rsp_sat_in   = res_sat;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         bandgap_ff   <= BANDGAP_RESET;
         avcc_ff      <= AVCC_RESET;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         bandgap_ff   <= bandgap_in;
         avcc_ff      <= avcc_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_sat_ff;

   abm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .stall  (out_full),
      .stat   (stat),
      .ctrl   (ctrl),
      .busy   (seq_busy),
      .emit   (emit)
   );

   abm_datapath u_dp (
      .clock      (clock),
      .ctrl       (ctrl),
      .sum        (sum_ff),
      .mode       (mode_ff),
      .bandgap_mv (bandgap_ff),
      .avcc_mv    (avcc_ff),
      .stat       (stat),
      .res_value  (res_value),
      .res_sat    (res_sat)
   );

`ifndef NO_ASSERTIONS
   // A result never overwrites one that is still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result emitted into a full output register");

   // A closing sample starts the engine
   a_close_runs: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser && pos_ff == POS_W'(BURST_LEN - 1)) |=> seq_busy)
      else $error("closing sample did not start the engine");

   // The output register fills only from the engine
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result appeared without an emit");
`endif

endmodule

[rtl/core/abm_ucode_rom.sv]
module abm_ucode_rom
   import abm_pkg::*;
(
   input  logic [STEP_W-1:0] step,
   output ucode_type         word
);

   // Program: average, then branch on mode
   always_comb begin
      word = UCODE_NOP;
      unique case (step)
         4'd0: begin  // sum / 3
            word.op     = OP_AVG;
            word.cond   = JMP_MODE_SUPPLY;
            word.target = 4'd3;
         end
         4'd1: begin
            word.cond   = JMP_MODE_SOLAR;
            word.target = 4'd8;
         end
         4'd2: begin  // raw average
            word.op   = OP_RES_AVG;
            word.last = 1'b1;
         end
         4'd3: begin  // supply: guard the zero average
            word.cond   = JMP_AVG_ZERO;
            word.target = 4'd7;
         end
         4'd4: word.op = OP_LOAD;
         4'd5: begin
            word.op     = OP_DIV_STEP;
            word.cond   = JMP_DIV_BUSY;
            word.target = 4'd5;
         end
         4'd6: begin
            word.op   = OP_RES_QUOT;
            word.last = 1'b1;
         end
         4'd7: begin
            word.op        = OP_RES_QUOT;
            word.force_sat = 1'b1;
            word.last      = 1'b1;
         end
         4'd8:  word.op = OP_MUL_AVCC;   // solar: avg * avcc
         4'd9:  word.op = OP_MUL_SOLAR;  // (prod >> 10) * 49
         4'd10: word.op = OP_DIV_TEN;    // / 10
         4'd11: begin
            word.op   = OP_RES_QUOT;
            word.last = 1'b1;
         end
         default: begin
            word.op   = OP_RES_AVG;
            word.last = 1'b1;
         end
      endcase
   end

endmodule

[rtl/core/abm_sequencer.sv]
module abm_sequencer
   import abm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      launch,
   input  logic      stall,
   input  stat_type  stat,
   output ucode_type ctrl,
   output logic      busy,
   output logic      emit
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   ucode_type         word;
   logic              take;

   abm_ucode_rom u_rom (
      .step (step_ff),
      .word (word)
   );

   always_comb begin
      unique case (word.cond)
         JMP_NONE:        take = 1'b0;
         JMP_ALWAYS:      take = 1'b1;
         JMP_DIV_BUSY:    take = stat.div_busy;
         JMP_MODE_SUPPLY: take = stat.mode_supply;
         JMP_MODE_SOLAR:  take = stat.mode_solar;
         JMP_AVG_ZERO:    take = stat.avg_zero;
         default:         take = 1'b0;
      endcase
   end

   assign ctrl = run_ff ? word : UCODE_NOP;
   assign busy = run_ff;
   assign emit = run_ff && word.last && !stall;

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      if (launch) begin
         run_in  = 1'b1;
         step_in = '0;
      end else if (run_ff) begin
         if (word.last) begin
            // hold on the final step until the output register frees up
            if (!stall) begin
               run_in  = 1'b0;
               step_in = '0;
            end
         end else begin
            step_in = take ? word.target : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

endmodule

[rtl/core/abm_datapath.sv]
module abm_datapath
   import abm_pkg::*;
(
   input  logic                 clock,
   input  ucode_type            ctrl,
   input  logic [SUM_W-1:0]     sum,
   input  logic [MODE_W-1:0]    mode,
   input  logic [BANDGAP_W-1:0] bandgap_mv,
   input  logic [AVCC_W-1:0]    avcc_mv,
   output stat_type             stat,
   output logic [VALUE_W-1:0]   res_value,
   output logic                 res_sat
);

   logic [AVG_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AVG_W-1:0]  avg_ff, avg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic [AVG_PROD_W-1:0] avg_prod;
   logic [AVG_W:0]        trial;
   logic                  fits;
   logic [VADC_W-1:0]     vadc;
   logic [M49_W-1:0]      m49;
   logic [TEN_PROD_W-1:0] ten_prod;
   logic                  quo_over;

   // floor of sum / 3 by reciprocal multiply
   assign avg_prod = sum * RECIP_W'(AVG_RECIP);

   // one restoring divide bit per step, divisor is the average
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, avg_ff};
   assign vadc  = prod_ff[PROD_W-1:FS_SHIFT];
   assign m49   = vadc * SOLAR_W'(SOLAR_NUM);

   // floor of x / 10 by reciprocal multiply
   assign ten_prod = prod_ff[M49_W-1:0] * RECIP_W'(TEN_RECIP);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      avg_in  = avg_ff;
      prod_in = prod_ff;
      unique case (ctrl.op)
         OP_AVG: avg_in = avg_prod[AVG_SHIFT +: AVG_W];
         OP_LOAD: begin
            rem_in = '0;
            quo_in = {bandgap_mv, {FS_SHIFT{1'b0}}};
            cnt_in = CNT_W'(DVD_W - 1);
         end
         OP_DIV_STEP: begin
            rem_in = fits ? AVG_W'(trial - {1'b0, avg_ff}) : trial[AVG_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_MUL_AVCC:  prod_in = avg_ff * avcc_mv;
         OP_MUL_SOLAR: prod_in = PROD_W'(m49);
         OP_DIV_TEN:   quo_in  = DVD_W'(ten_prod[TEN_SHIFT +: TEN_Q_W]);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      avg_ff  <= avg_in;
      prod_ff <= prod_in;
   end

   assign stat.div_busy    = cnt_ff != '0;
   assign stat.mode_supply = mode == MODE_SUPPLY;
   assign stat.mode_solar  = mode == MODE_SOLAR;
   assign stat.avg_zero    = avg_ff == '0;

   // clip anything past 16 bits
   assign quo_over = |quo_ff[DVD_W-1:VALUE_W];

   always_comb begin
      if (ctrl.op == OP_RES_AVG) begin
         res_value = VALUE_W'(avg_ff);
         res_sat   = 1'b0;
      end else begin
         res_sat   = quo_over || ctrl.force_sat;
         res_value = res_sat ? '1 : quo_ff[VALUE_W-1:0];
      end
   end

endmodule
